[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam logic [31:0] FNV_BASIS  = 32'h811C_9DC5;
    localparam logic [31:0] FNV_FACTOR = 32'h0100_0193;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // finished key, handed from the hasher to the engine
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] value;
        logic [31:0] hash;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [6:0]  entry_count;
    } res_t;

endpackage

[rtl/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table keyed by FNV-1a hashes of byte strings.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser                  tlast
//  s_axis    in   key_byte, value_in             operation, byte_valid  key_last
//  m_axis    out  value_out, entry_count         status                 -
//
//  Key bytes stream in while the engine is idle. The last byte then runs the
//  operation: the probe starts at the hash's low bits for a power-of-two slot
//  count, else at the lpht_mod remainder; a half-load insert returns full.
//  After reset a clearing pass over all TABLE_SLOTS slots holds s_tready low.
//  One result may wait in the output register while the next key streams in.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key_byte[7:0], value_in[39:8]
    input  logic [2:0]  s_tuser,   // operation[1:0], byte_valid[2]
    input  logic        s_tlast,   // key_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value_out[31:0], entry_count[38:32], zero[39]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic             s_accept;
    logic [31:0]      key_hash;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             mod_start;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    logic             m_valid_reg;
    res_t             m_res_reg;

    assign s_accept  = s_tvalid && s_tready;
    assign cmd_valid = s_accept && s_tlast;
    assign cmd       = '{operation: s_tuser[1:0], value: s_tdata[39:8], hash: key_hash};

    lpht_hasher u_hasher (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .key_byte   (s_tdata[7:0]),
        .byte_valid (s_tuser[2]),
        .key_last   (s_tlast),
        .hash       (key_hash)
    );

    lpht_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cmd.hash),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    lpht_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ready     (s_tready),
        .mod_start (mod_start),
        .mod_done  (mod_done),
        .mod_rem   (mod_rem),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register: refills on the cycle the held result is taken
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (res_ready)
            m_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            m_res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.entry_count, m_res_reg.value};
    assign m_tuser  = m_res_reg.status;

endmodule

[rtl/lpht_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hasher
// FNV-1a accumulator: folds one key byte per transfer that has byte_valid set,
// restarts after the last byte of a key.
// ----------------------------------------------------------------------------
module lpht_hasher
    import lpht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  key_byte,
    input  logic        byte_valid,
    input  logic        key_last,
    output logic [31:0] hash
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] mixed;
    logic [31:0] folded;

    assign mixed  = acc_reg ^ {24'd0, key_byte};
    assign folded = mixed * FNV_FACTOR;
    assign hash   = byte_valid ? folded : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            if (key_last)
                acc_next = FNV_BASIS;
            else if (byte_valid)
                acc_next = folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= FNV_BASIS;
        else
            acc_reg <= acc_next;
    end

endmodule

[rtl/lpht_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_mod
// Remainder of a 32-bit hash by the slot count through a reciprocal
// multiplication, with the quotient, product and remainder registered in turn.
// ----------------------------------------------------------------------------
module lpht_mod
#(
    parameter int TABLE_SLOTS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [31:0]                    dividend,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] rem
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [31:0] DIVISOR = 32'(TABLE_SLOTS);
    // floor(2^32 / slots): the quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SLOTS));

    logic [2:0]       stage_reg;
    logic             done_reg;
    logic [31:0]      sh_reg;
    logic [31:0]      quot_reg;
    logic [31:0]      prod_reg;
    logic [IDX_W-1:0] rem_reg;
    logic [31:0]      quot_est;
    logic [31:0]      diff;

    assign quot_est = 32'((64'(sh_reg) * 64'(RECIP)) >> 32);
    // below twice the divisor, so one compare and subtract finishes it
    assign diff     = sh_reg - prod_reg;
    assign done     = done_reg;
    assign rem      = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], start};
            done_reg  <= stage_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            sh_reg <= dividend;
        if (stage_reg[0])
            quot_reg <= quot_est;
        if (stage_reg[1])
            prod_reg <= quot_reg * DIVISOR;
        if (stage_reg[2])
            rem_reg <= (diff >= DIVISOR) ? IDX_W'(diff - DIVISOR) : IDX_W'(diff);
    end

endmodule

[rtl/lpht_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_engine
// Slot memories and the probe sequencer: clears the table after reset, then
// runs insert, lookup and remove one slot read per cycle; the unused opcode misses.
// ----------------------------------------------------------------------------
module lpht_engine
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  cmd_t                           cmd,
    output logic                           ready,
    output logic                           mod_start,
    input  logic                           mod_done,
    input  logic [$clog2(TABLE_SLOTS)-1:0] mod_rem,
    output logic                           res_valid,
    output res_t                           res,
    input  logic                           res_ready
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int HALF  = TABLE_SLOTS / 2;
    localparam int CNT_W = $clog2(HALF + 1);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    // slot word: live flag above the stored hash
    logic [32:0] slot_mem [TABLE_SLOTS];
    logic [31:0] value_mem [TABLE_SLOTS];

    logic [2:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [31:0]      hash_reg, hash_next;
    logic [31:0]      val_reg, val_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    res_t             res_reg, res_next;

    logic [IDX_W-1:0] idx_nx;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             slot_we;
    logic [32:0]      slot_wdata;
    logic             value_we;
    logic [32:0]      slot_rdata_reg;
    logic [31:0]      value_rdata_reg;

    logic             rd_live;
    logic [31:0]      rd_hash;
    logic             last_probe;
    logic             needs_probe;
    logic [CNT_W+6:0] count_ext;

    assign idx_nx     = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign rd_addr    = (state_reg == S_CHECK) ? idx_nx : idx_reg;
    assign rd_live    = slot_rdata_reg[32];
    assign rd_hash    = slot_rdata_reg[31:0];
    assign last_probe = (probe_reg == LAST_IDX);
    assign needs_probe = (cmd.operation == OP_LOOKUP) || (cmd.operation == OP_REMOVE) ||
                         ((cmd.operation == OP_INSERT) && (count_reg < HALF_CNT));
    assign count_ext  = {7'd0, count_next};

    assign ready     = (state_reg == S_IDLE);
    assign mod_start = (state_reg == S_IDLE) && cmd_valid && needs_probe && !IS_POW2;
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        hash_next  = hash_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        probe_next = probe_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        res_next   = res_reg;
        slot_we    = 1'b0;
        slot_wdata = '0;
        value_we   = 1'b0;
        wr_addr    = idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we  = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd.operation;
                    hash_next  = cmd.hash;
                    val_next   = cmd.value;
                    probe_next = '0;
                    res_next   = '{status: ST_MISS, value: 32'd0,
                                   entry_count: count_ext[6:0]};
                    priority if ((cmd.operation == OP_INSERT) && !needs_probe)
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_RESULT;
                    end
                    else if (!needs_probe)
                        state_next = S_RESULT;
                    else if (IS_POW2)
                    begin
                        idx_next   = cmd.hash[IDX_W-1:0];
                        state_next = S_READ;
                    end
                    else
                        state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    idx_next   = mod_rem;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // slot data read in the previous cycle belongs to idx_reg
                priority if ((op_reg == OP_INSERT) && !rd_live)
                begin
                    slot_we         = 1'b1;
                    slot_wdata      = {1'b1, hash_reg};
                    value_we        = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_next.status = ST_OK;
                    state_next      = S_RESULT;
                end
                else if ((op_reg != OP_INSERT) && !rd_live && (rd_hash == 32'd0))
                begin
                    res_next.status = ST_MISS;
                    state_next      = S_RESULT;
                end
                else if ((op_reg != OP_INSERT) && rd_live && (rd_hash == hash_reg))
                begin
                    res_next.status = ST_OK;
                    if (op_reg == OP_LOOKUP)
                        res_next.value = value_rdata_reg;
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = {1'b0, rd_hash};
                        if (count_reg != '0)
                            count_next = count_reg - 1'b1;
                    end
                    state_next = S_RESULT;
                end
                else if (last_probe)
                begin
                    res_next.status = (op_reg == OP_INSERT) ? ST_FULL : ST_MISS;
                    state_next      = S_RESULT;
                end
                else
                begin
                    idx_next   = idx_nx;
                    probe_next = probe_reg + 1'b1;
                end
                res_next.entry_count = count_ext[6:0];
            end
            S_RESULT:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        hash_reg  <= hash_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[wr_addr] <= slot_wdata;
        slot_rdata_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
            value_mem[wr_addr] <= val_reg;
        value_rdata_reg <= value_mem[rd_addr];
    end

endmodule

[tb/tb_linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Streams byte-wise keys into the hash table and checks every reply.
// A mirror of the table (FNV-1a accumulator, slot hashes, values, live flags)
// predicts status, value and entry count per finished key. A short directed
// run covers empty keys, the unused opcode, ignored bytes and a removed entry
// whose hash is zero; random keys then insert, look up and remove entries
// under three flow-control phases.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table
    import lpht_pkg::*;
();

    localparam int         TABLE_SLOTS = 64;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][7:0] bytes;   // bytes[0] is sent first
    } key_t;

    class table_scoreboard;
        logic [31:0] running_hash;
        logic [31:0] slot_hash  [TABLE_SLOTS];
        logic [31:0] slot_value [TABLE_SLOTS];
        bit          slot_live  [TABLE_SLOTS];
        int unsigned live_entries;
        res_t        pending_replies [$];
        int unsigned mismatches;
        int unsigned replies_checked;
        int unsigned status_seen [4];

        function new();
            running_hash = FNV_BASIS;
            live_entries = 0;
            mismatches = 0;
            replies_checked = 0;
            foreach (slot_hash[i])
            begin
                slot_hash[i] = '0;
                slot_value[i] = '0;
                slot_live[i] = 1'b0;
            end
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // first live slot holding h; a dead slot with hash zero ends the probe
        function int find_live(logic [31:0] h);
            int idx;
            idx = int'(h % TABLE_SLOTS);
            for (int n = 0; n < TABLE_SLOTS; n++)
            begin
                if (!slot_live[idx] && slot_hash[idx] == 32'd0)
                    return -1;
                if (slot_live[idx] && slot_hash[idx] == h)
                    return idx;
                idx = (idx + 1) % TABLE_SLOTS;
            end
            return -1;
        endfunction

        function void absorb_key_item(logic [1:0] op, logic [7:0] kb, logic kv, logic kl,
                                      logic [31:0] val);
            logic [31:0] h;
            int          idx;
            res_t        r;
            if (kv)
                running_hash = (running_hash ^ {24'd0, kb}) * FNV_FACTOR;
            if (!kl)
                return;
            h = running_hash;
            running_hash = FNV_BASIS;
            r.status = ST_MISS;
            r.value = '0;
            case (op)
                OP_INSERT:
                begin
                    if (live_entries >= TABLE_SLOTS / 2)
                        r.status = ST_FULL;
                    else
                    begin
                        idx = int'(h % TABLE_SLOTS);
                        while (slot_live[idx])
                            idx = (idx + 1) % TABLE_SLOTS;
                        slot_hash[idx] = h;
                        slot_value[idx] = val;
                        slot_live[idx] = 1'b1;
                        live_entries++;
                        r.status = ST_OK;
                    end
                end
                OP_LOOKUP:
                begin
                    idx = find_live(h);
                    if (idx >= 0)
                    begin
                        r.status = ST_OK;
                        r.value = slot_value[idx];
                    end
                end
                OP_REMOVE:
                begin
                    idx = find_live(h);
                    if (idx >= 0)
                    begin
                        slot_live[idx] = 1'b0;   // hash stays as tombstone
                        live_entries--;
                        r.status = ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_count = live_entries[6:0];
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [31:0] v, logic [6:0] cnt);
            res_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t ns: reply with none pending: status %0d value %h count %0d",
                         $time, st, v, cnt);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            replies_checked++;
            if (!$isunknown(st))
                status_seen[st]++;
            if (st !== want.status)
            begin
                $display("%0t ns: status expected %0d actual %0d", $time, want.status, st);
                mismatches++;
            end
            if (v !== want.value)
            begin
                $display("%0t ns: value_out expected %h actual %h", $time, want.value, v);
                mismatches++;
            end
            if (cnt !== want.entry_count)
            begin
                $display("%0t ns: entry_count expected %0d actual %0d",
                         $time, want.entry_count, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // key_byte[7:0], value_in[39:8]
    logic [2:0]  s_tuser;    // operation[1:0], byte_valid[2]
    logic        s_tlast;    // key_last
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // value_out[31:0], entry_count[38:32], zero[39]
    logic [1:0]  m_tuser;    // status[1:0]

    table_scoreboard sb = new();

    int   send_idle_pct;
    int   recv_idle_pct;
    int   noise_pct;
    int   items_driven;
    key_t zero_key;
    key_t slot0_key;
    key_t empty_key;
    key_t key_pool [$];

    linear_probe_hash_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready)
            sb.check_reply(m_tuser, m_tdata[31:0], m_tdata[38:32]);
    end

    // A 5-byte key hashing to zero (meet in the middle over the invertible
    // FNV-1a rounds) and a short key landing on slot 0.
    task automatic build_corner_keys();
        logic [31:0] pinv;
        logic [31:0] t;
        logic [31:0] h;
        logic [23:0] hit;
        logic [23:0] tail_by_top [logic [23:0]];
        bit          found;
        pinv = FNV_FACTOR;
        repeat (5) pinv = pinv * (32'd2 - FNV_FACTOR * pinv);
        for (int k3 = 0; k3 < 256; k3++)
            for (int k4 = 0; k4 < 256; k4++)
            begin
                t = (((32'(k4) * pinv) ^ 32'(k3))) * pinv;
                tail_by_top[t[31:8]] = {t[7:0], 8'(k3), 8'(k4)};
            end
        found = 1'b0;
        zero_key = '0;
        for (int k0 = 0; k0 < 256 && !found; k0++)
            for (int k1 = 0; k1 < 256 && !found; k1++)
            begin
                h = (((FNV_BASIS ^ 32'(k0)) * FNV_FACTOR) ^ 32'(k1)) * FNV_FACTOR;
                if (tail_by_top.exists(h[31:8]))
                begin
                    hit = tail_by_top[h[31:8]];
                    zero_key.len = 4'd5;
                    zero_key.bytes[0] = 8'(k0);
                    zero_key.bytes[1] = 8'(k1);
                    zero_key.bytes[2] = h[7:0] ^ hit[23:16];
                    zero_key.bytes[3] = hit[15:8];
                    zero_key.bytes[4] = hit[7:0];
                    found = 1'b1;
                end
            end
        found = 1'b0;
        slot0_key = '0;
        for (int a = 0; a < 256 && !found; a++)
            for (int b = 0; b < 256 && !found; b++)
            begin
                h = (((FNV_BASIS ^ 32'(a)) * FNV_FACTOR) ^ 32'(b)) * FNV_FACTOR;
                if (h[5:0] == 6'd0 && h != 32'd0)
                begin
                    slot0_key.len = 4'd2;
                    slot0_key.bytes[0] = 8'(a);
                    slot0_key.bytes[1] = 8'(b);
                    found = 1'b1;
                end
            end
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic [1:0] op, logic [7:0] kb, logic kv, logic kl,
                             logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, kb};
        s_tuser  <= {kv, op};
        s_tlast  <= kl;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.absorb_key_item(op, kb, kv, kl, val);
        if (kv || kl)
            items_driven++;
        @(negedge clk);
    endtask

    task automatic send_key(key_t k, logic [1:0] op, logic [31:0] val);
        bit tail_carries;
        tail_carries = (k.len != 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < k.len; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(2'($urandom_range(3)), 8'($urandom), 1'b0, 1'b0, $urandom);
            if (tail_carries && i == k.len - 1)
                send_item(op, k.bytes[i], 1'b1, 1'b1, val);
            else
                send_item(2'($urandom_range(3)), k.bytes[i], 1'b1, 1'b0, $urandom);
        end
        if (!tail_carries)
            send_item(op, 8'($urandom), 1'b0, 1'b1, val);
    endtask

    function automatic key_t random_key();
        key_t k;
        int   r;
        k = '0;
        r = $urandom_range(99);
        if (r < 5)
            k.len = 4'd0;
        else if (r < 75)
            k.len = 4'($urandom_range(1, 3));
        else
            k.len = 4'($urandom_range(4, 8));
        for (int i = 0; i < k.len; i++)
        begin
            k.bytes[i] = 8'($urandom);
            if ($urandom_range(9) == 0)
                k.bytes[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return k;
    endfunction

    task automatic drive_random_key();
        key_t        k;
        logic [1:0]  op;
        logic [31:0] val;
        int          r;
        bit          reuse;
        r = $urandom_range(99);
        op = (r < 45) ? OP_INSERT : (r < 75) ? OP_LOOKUP : (r < 94) ? OP_REMOVE : OP_UNUSED;
        // lookups and removals mostly target keys already inserted
        if (op == OP_INSERT)
            reuse = ($urandom_range(3) == 0);
        else
            reuse = ($urandom_range(4) != 0);
        if (reuse && key_pool.size() > 0)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else
        begin
            k = random_key();
            if (op == OP_INSERT)
            begin
                key_pool.push_back(k);
                if (key_pool.size() > 48)
                    void'(key_pool.pop_front());
            end
        end
        val = $urandom;
        if ($urandom_range(15) == 0)
            val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        send_key(k, op, val);
    endtask

    initial
    begin
        int phase_end;
        int directed_items;
        key_t k;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 53;
        noise_pct = 0;
        items_driven = 0;
        empty_key = '0;
        build_corner_keys();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // removing a zero-hash entry leaves a tombstone that looks never used,
        // so the later lookup of a key probing from slot 0 misses
        send_key(zero_key, OP_INSERT, 32'hFFFF_FFFF);
        send_key(slot0_key, OP_INSERT, 32'h0000_0000);
        send_key(zero_key, OP_REMOVE, 32'h0000_0000);
        send_key(slot0_key, OP_LOOKUP, 32'h0000_0000);
        send_key(empty_key, OP_INSERT, 32'hA5A5_5A5A);
        send_key(empty_key, OP_LOOKUP, 32'h0000_0000);
        send_key(empty_key, OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 8'hFF, 1'b0, 1'b0, 32'h1234_5678);   // ignored
        k = '0;
        k.len = 4'd1;
        k.bytes[0] = 8'hFF;
        send_key(k, OP_LOOKUP, 32'h0000_0000);
        k.bytes[0] = 8'h00;
        send_key(k, OP_INSERT, 32'h0000_0001);
        send_key(empty_key, OP_REMOVE, 32'h0000_0000);
        send_key(empty_key, OP_REMOVE, 32'h0000_0000);
        directed_items = items_driven;

        noise_pct = 8;
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 36 : (p == 1) ? 53 : 0;
            recv_idle_pct = (p == 0) ? 53 : (p == 1) ? 36 : 0;
            phase_end = items_driven + 140;
            while (items_driven < phase_end)
                drive_random_key();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Drove %0d key items (%0d directed) under three flow-control phases",
                 items_driven, directed_items);
        $display("Checked %0d replies: %0d done or found, %0d not found, %0d table full",
                 sb.replies_checked, sb.status_seen[ST_OK], sb.status_seen[ST_MISS],
                 sb.status_seen[ST_FULL]);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
